// ----- design/ctn_pkg.sv -----
// Shared types, constants and sequencer states of the chirp/tone/noise generator.
`default_nettype none

package ctn_pkg;

    // Sine lookup resolution: 2^SINE_BITS points per wave period
    localparam int SINE_BITS    = 10;
    localparam int QUARTER_BITS = SINE_BITS - 2;
    localparam int X_SHIFT      = 17 - SINE_BITS;

    localparam int SAMPLE_W   = 16;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic [CFG_INDEX_W-1:0]     cfg_index_t;
    typedef logic [CFG_DATA_W-1:0]      cfg_data_t;

    // Register indexes of the write port
    localparam cfg_index_t CFG_MODE       = 3'd0;
    localparam cfg_index_t CFG_STEP_START = 3'd1;
    localparam cfg_index_t CFG_STEP_DELTA = 3'd2;
    localparam cfg_index_t CFG_LENGTH     = 3'd3;
    localparam cfg_index_t CFG_VOLUME     = 3'd4;
    localparam cfg_index_t CFG_ATTACK     = 3'd5;
    localparam cfg_index_t CFG_RELEASE    = 3'd6;

    // Waveform modes
    localparam logic [1:0] MODE_TONE  = 2'd0;
    localparam logic [1:0] MODE_NOISE = 2'd1;
    localparam logic [1:0] MODE_MIX   = 2'd2;

    localparam logic [31:0] LFSR_SEED = 32'h0000_ACE1;
    localparam logic [31:0] LFSR_TAPS = 32'hD000_0001;

    // Quarter-wave polynomial coefficients
    localparam logic signed [16:0] POLY_C1 = 17'sd51472;
    localparam logic signed [16:0] POLY_C3 = 17'sd21167;
    localparam logic signed [16:0] POLY_C5 = 17'sd2463;

    localparam logic [15:0] ENV_FULL  = 16'h8000;
    localparam logic [3:0]  DIV_STEPS = 4'd15;

    localparam logic signed [18:0] SAT_HI = 19'sd32760;
    localparam logic signed [18:0] SAT_LO = -19'sd32760;

    typedef enum logic [3:0] {
        S_IDLE,
        S_X2,
        S_X3,
        S_X5,
        S_T1,
        S_T2,
        S_T3,
        S_DIV,
        S_M1,
        S_M2,
        S_SCALE,
        S_ROUND,
        S_OUT
    } ctn_state_t;

endpackage

`default_nettype wire

// ----- design/ctn_in_if.sv -----
// Input channel: one word carries the sample to mix with.
`default_nettype none

interface ctn_in_if;
    import ctn_pkg::*;

    logic    valid;
    logic    ready;
    sample_t existing_sample;

    modport source (output valid, output existing_sample, input ready);
    modport sink   (input valid, input existing_sample, output ready);
endinterface

`default_nettype wire

// ----- design/ctn_out_if.sv -----
// Output channel: one word carries a generated sample and the end-of-run flag.
`default_nettype none

interface ctn_out_if;
    import ctn_pkg::*;

    logic    valid;
    logic    ready;
    sample_t sample_out;
    logic    last_of_run;

    modport source (output valid, output sample_out, output last_of_run, input ready);
    modport sink   (input valid, input sample_out, input last_of_run, output ready);
endinterface

`default_nettype wire

// ----- design/chirp_tone_noise_generator.sv -----
// Chirp, tone and noise sample generator with linear envelope, top level.
//
// Usage: each word taken on "item" produces exactly one word on "result". In tone
// mode the pitch sweeps linearly from the start step by the signed delta per sample;
// noise mode uses a 32-bit LFSR; mix mode adds the tone to item.existing_sample.
// The user writes registers through wr_en/wr_index/wr_data only while the block is
// idle; the block itself does not enforce this.
//
// Datapath: one shared 34x17 multiplier computes the sine polynomial and the gain
// chain, and a radix-2 divider makes the envelope alongside the polynomial. Noise
// words skip the polynomial steps; S_DIV holds while an attack or release ramp is
// still dividing. The next word is taken the cycle after the result has moved into
// the output register.
//
// Reset: registers take their defaults (mode tone, length 1, full volume, no fades),
// the run index and phase clear and the LFSR is seeded with 0xACE1.
// Stall: a result waits in the output register while result.ready is low; the
// next item may be accepted and computed meanwhile, and it holds in its final
// step until the output register frees.
`default_nettype none

module chirp_tone_noise_generator (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    ctn_in_if.sink                     item,
    ctn_out_if.source                  result,
    input  wire logic                  wr_en,
    input  wire ctn_pkg::cfg_index_t   wr_index,
    input  wire ctn_pkg::cfg_data_t    wr_data
);
    import ctn_pkg::*;

    // configuration
    logic [1:0]  mode_reg;
    logic [30:0] step_start_reg;
    logic [31:0] step_delta_reg;
    logic [15:0] length_reg;
    logic [15:0] volume_reg;
    logic [11:0] attack_reg;
    logic [11:0] release_reg;

    // run state
    logic [15:0] sample_index_reg;
    logic [31:0] phase_acc_reg;
    logic [31:0] phase_step_reg;
    logic [31:0] lfsr_reg;

    ctn_state_t  state_reg, state_next;
    logic        out_valid_reg;
    logic [3:0]  div_cnt_reg;

    // working registers
    sample_t            existing_reg;
    logic [15:0]        x_reg, x2_reg, x3_reg, x5_reg;
    logic signed [32:0] acc_reg;
    logic signed [16:0] wave_reg;
    logic [15:0]        env_reg;
    logic [11:0]        div_r_reg, div_d_reg;
    logic signed [33:0] p1_reg;
    logic signed [47:0] g_reg;
    logic signed [63:0] num_reg;
    sample_t            res_reg;
    logic               last_reg, neg_reg, noise_reg;
    sample_t            sample_out_reg;
    logic               last_out_reg;

    // accept-cycle logic
    logic        accept, slot_free;
    logic [16:0] len_c, idx_c, rem_c;
    logic        last_c, first_c;
    logic [31:0] eff_acc, eff_step, lfsr_next;
    logic [SINE_BITS-1:0]    sine_idx;
    logic [1:0]              quad;
    logic [SINE_BITS-2:0]    p_ext;
    logic [15:0]             x_c;
    logic        rel_on, att_on, div_go;
    logic [11:0] div_n, div_d;

    // shared multiplier and later steps
    logic signed [33:0] mul_a;
    logic signed [16:0] mul_b;
    logic signed [50:0] mul_p;
    logic [12:0]        div_r2;
    logic               div_ge;
    logic signed [16:0] sine_mag;
    logic signed [63:0] g_ext, num_c;
    logic signed [18:0] mix_add, sum_hi, q_c;
    logic               low_nz;
    sample_t            res_c;

    localparam logic [SINE_BITS-2:0] QLEN = (SINE_BITS-1)'(1 << QUARTER_BITS);

    assign accept    = item.valid && item.ready;
    assign slot_free = !out_valid_reg || result.ready;

    assign item.ready         = (state_reg == S_IDLE);
    assign result.valid       = out_valid_reg;
    assign result.sample_out  = sample_out_reg;
    assign result.last_of_run = last_out_reg;

    // run position, phase and noise for the incoming word
    always_comb
    begin
        len_c    = (length_reg == 16'd0) ? 17'h10000 : {1'b0, length_reg};
        idx_c    = {1'b0, sample_index_reg};
        rem_c    = (idx_c < len_c) ? (len_c - idx_c) : 17'd1;
        last_c   = ((idx_c + 17'd1) >= len_c);
        first_c  = (sample_index_reg == 16'd0);
        eff_acc  = first_c ? 32'd0 : phase_acc_reg;
        eff_step = first_c ? {1'b0, step_start_reg} : phase_step_reg;

        lfsr_next = {1'b0, lfsr_reg[31:1]} ^ (lfsr_reg[0] ? LFSR_TAPS : 32'd0);

        sine_idx = eff_acc[31 -: SINE_BITS];
        quad     = sine_idx[SINE_BITS-1 -: 2];
        p_ext    = {1'b0, sine_idx[QUARTER_BITS-1:0]};
        if (quad[0])
        begin
            p_ext = QLEN - p_ext;
        end
        x_c = 16'(p_ext) << X_SHIFT;

        // release wins over attack
        rel_on = (release_reg != 12'd0) && (rem_c < {5'd0, release_reg});
        att_on = (attack_reg != 12'd0) && (idx_c < {5'd0, attack_reg});
        div_go = rel_on || att_on;
        div_n  = rel_on ? rem_c[11:0] : idx_c[11:0];
        div_d  = rel_on ? release_reg : attack_reg;
    end

    // shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_X2:
            begin
                mul_a = $signed({18'd0, x_reg});
                mul_b = $signed({1'b0, x_reg});
            end
            S_X3:
            begin
                mul_a = $signed({18'd0, x2_reg});
                mul_b = $signed({1'b0, x_reg});
            end
            S_X5:
            begin
                mul_a = $signed({18'd0, x3_reg});
                mul_b = $signed({1'b0, x2_reg});
            end
            S_T1:
            begin
                mul_a = $signed({18'd0, x_reg});
                mul_b = POLY_C1;
            end
            S_T2:
            begin
                mul_a = $signed({18'd0, x5_reg});
                mul_b = POLY_C5;
            end
            S_T3:
            begin
                mul_a = $signed({18'd0, x3_reg});
                mul_b = POLY_C3;
            end
            S_M1:
            begin
                mul_a = 34'(wave_reg);
                mul_b = $signed({1'b0, env_reg});
            end
            S_M2:
            begin
                mul_a = p1_reg;
                mul_b = $signed({1'b0, volume_reg});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = 51'(mul_a) * 51'(mul_b);

    // divider step, quotient scaling, rounding toward zero and saturation
    always_comb
    begin
        div_r2   = {div_r_reg, 1'b0};
        div_ge   = (div_r2 >= {1'b0, div_d_reg});
        sine_mag = $signed({1'b0, acc_reg[30:15]});

        g_ext = 64'(g_reg);
        num_c = (g_ext <<< 15) - (g_ext <<< 3);

        mix_add = (mode_reg == MODE_MIX) ? 19'(existing_reg) : 19'sd0;
        sum_hi  = $signed(num_reg[63:45]) + mix_add;
        low_nz  = |num_reg[44:0];
        q_c     = sum_hi + $signed({18'd0, sum_hi[18] & low_nz});

        priority if (q_c > SAT_HI)
        begin
            res_c = SAT_HI[15:0];
        end
        else if (q_c < SAT_LO)
        begin
            res_c = SAT_LO[15:0];
        end
        else
        begin
            res_c = q_c[15:0];
        end
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = (mode_reg == MODE_NOISE) ? S_DIV : S_X2;
                end
            end
            S_X2:    state_next = S_X3;
            S_X3:    state_next = S_X5;
            S_X5:    state_next = S_T1;
            S_T1:    state_next = S_T2;
            S_T2:    state_next = S_T3;
            S_T3:    state_next = S_DIV;
            S_DIV:
            begin
                if (div_cnt_reg == 4'd0)
                begin
                    state_next = S_M1;
                end
            end
            S_M1:    state_next = S_M2;
            S_M2:    state_next = S_SCALE;
            S_SCALE: state_next = S_ROUND;
            S_ROUND: state_next = S_OUT;
            S_OUT:
            begin
                if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // control state, configuration and run state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg         <= MODE_TONE;
            step_start_reg   <= '0;
            step_delta_reg   <= '0;
            length_reg       <= 16'd1;
            volume_reg       <= ENV_FULL;
            attack_reg       <= '0;
            release_reg      <= '0;
            sample_index_reg <= '0;
            phase_acc_reg    <= '0;
            phase_step_reg   <= '0;
            lfsr_reg         <= LFSR_SEED;
            out_valid_reg    <= 1'b0;
            div_cnt_reg      <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                unique case (wr_index)
                    CFG_MODE:       mode_reg       <= wr_data[1:0];
                    CFG_STEP_START: step_start_reg <= wr_data[30:0];
                    CFG_STEP_DELTA: step_delta_reg <= wr_data;
                    CFG_LENGTH:     length_reg     <= wr_data[15:0];
                    CFG_VOLUME:     volume_reg     <= wr_data[15:0];
                    CFG_ATTACK:     attack_reg     <= wr_data[11:0];
                    CFG_RELEASE:    release_reg    <= wr_data[11:0];
                    default:        ;
                endcase
            end

            // advance the run and the oscillator once per accepted word
            if (accept)
            begin
                sample_index_reg <= last_c ? 16'd0 : (sample_index_reg + 16'd1);
                phase_acc_reg    <= eff_acc + eff_step;
                phase_step_reg   <= eff_step + step_delta_reg;
                lfsr_reg         <= lfsr_next;
                div_cnt_reg      <= div_go ? DIV_STEPS : 4'd0;
            end
            else if (div_cnt_reg != 4'd0)
            begin
                div_cnt_reg <= div_cnt_reg - 4'd1;
            end

            if (state_reg == S_OUT && slot_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            existing_reg <= item.existing_sample;
            last_reg     <= last_c;
            x_reg        <= x_c;
            neg_reg      <= quad[1];
            noise_reg    <= (mode_reg == MODE_NOISE);
            wave_reg     <= 17'($signed(lfsr_next[15:0]));
            env_reg      <= div_go ? 16'd0 : ENV_FULL;
            div_r_reg    <= div_n;
            div_d_reg    <= div_d;
        end
        else if (div_cnt_reg != 4'd0)
        begin
            // one quotient bit per cycle, remainder stays below the divisor
            div_r_reg <= div_ge ? 12'(div_r2 - {1'b0, div_d_reg}) : div_r2[11:0];
            env_reg   <= {env_reg[14:0], div_ge};
        end

        unique case (state_reg)
            S_X2:    x2_reg  <= mul_p[30:15];
            S_X3:    x3_reg  <= mul_p[30:15];
            S_X5:    x5_reg  <= mul_p[30:15];
            S_T1:    acc_reg <= $signed(mul_p[32:0]);
            S_T2:    acc_reg <= acc_reg + $signed(mul_p[32:0]);
            S_T3:    acc_reg <= acc_reg - $signed(mul_p[32:0]);
            S_DIV:
            begin
                if (!noise_reg)
                begin
                    wave_reg <= neg_reg ? -sine_mag : sine_mag;
                end
            end
            S_M1:    p1_reg  <= mul_p[33:0];
            S_M2:    g_reg   <= mul_p[47:0];
            S_SCALE: num_reg <= num_c;
            S_ROUND: res_reg <= res_c;
            S_OUT:
            begin
                if (slot_free)
                begin
                    sample_out_reg <= res_reg;
                    last_out_reg   <= last_reg;
                end
            end
            default: ;
        endcase
    end

    // checks
    a_idle_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> div_cnt_reg == 4'd0)
        else $error("envelope divider still busy in idle");

    a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ($signed(sample_out_reg) <= 16'sd32760 &&
                           $signed(sample_out_reg) >= -16'sd32760))
        else $error("output sample outside saturation range");

    a_run_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && last_c) |=> sample_index_reg == 16'd0)
        else $error("run index did not wrap after last sample");

    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT && slot_free) |=> (out_valid_reg && state_reg == S_IDLE))
        else $error("finished word not moved to output register");

    a_lfsr_live: assert property (@(posedge clk) disable iff (!rst_n)
        lfsr_reg != 32'd0)
        else $error("noise LFSR locked at zero");

endmodule

`default_nettype wire
